>>> rtl/rsf_pkg.sv
// Shared types and constants for the resonant filter with saturated feedback.
// Used by the coefficient unit, the filter top level and the port checker.
`timescale 1ns / 1ps
`default_nettype none

package rsf_pkg;

    localparam int UPDATE_INTERVAL_DEF = 16;

    // Number formats: samples Q1.15, state Q5.27, coefficients Q1.17.
    localparam int SAMPLE_W = 16;
    localparam int STATE_W  = 32;
    localparam int COEF_W   = 18;
    localparam int MEM_DEPTH = 7;
    localparam int MEM_AW    = 3;

    // Configuration port.
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF_LEVEL   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESONANCE_GAIN = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF_OFFSET  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE_HZ = 8'd3;

    localparam int CUTOFF_W = 15;
    localparam int RES_W    = 16;
    localparam int OFFS_W   = 16;
    localparam int FS_W     = 18;

    // Coefficient arithmetic constants.
    localparam logic [25:0] K_Q8     = 26'd35467324;   // 2*pi*22050 in Q.8
    localparam logic [9:0]  OFFS_Q18 = 10'd524;        // 0.002 in Q.18
    localparam logic [15:0] GAIN_Q16 = 16'd21627;      // 0.33 in Q.16

    typedef struct packed {
        logic [COEF_W-1:0] low_a;
        logic [COEF_W-1:0] low_b;
        logic [COEF_W-1:0] high_a;
    } coeff_set_t;

endpackage

`default_nettype wire

>>> rtl/rsf_coeff_unit.sv
// Coefficient unit: recomputes the two lowpass and the highpass coefficients.
// Holds one multiplier and an 18-step restoring divider. Depends on rsf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rsf_coeff_unit
    import rsf_pkg::*;
(
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       start,
    input  wire logic [CUTOFF_W-1:0]        cutoff_level,
    input  wire logic signed [OFFS_W-1:0]   cutoff_offset,
    input  wire logic [FS_W-1:0]            sample_rate_hz,
    output logic                            done,
    output coeff_set_t                      coeff
);

    localparam int C_W   = 19;            // modulated cutoff, Q.18
    localparam int P_W   = 45;            // K * c
    localparam int FSQ_W = FS_W + 26;     // fs << 26
    localparam int D_W   = 46;            // divisor
    localparam int N_W   = 63;            // dividend
    localparam int Q_W   = 18;            // quotient bits

    localparam logic [1:0] JOB_LA = 2'd0;
    localparam logic [1:0] JOB_LB = 2'd1;
    localparam logic [1:0] JOB_HA = 2'd2;

    typedef enum logic [5:0] {
        CS_IDLE  = 6'b000001,
        CS_PREP  = 6'b000010,
        CS_MUL   = 6'b000100,
        CS_LOAD  = 6'b001000,
        CS_DIV   = 6'b010000,
        CS_STORE = 6'b100000
    } cstate_t;

    cstate_t          state_reg, state_next;
    logic [1:0]       job_reg, job_next;
    logic [4:0]       iter_reg, iter_next;
    logic [C_W-1:0]   ca_reg, cb_reg;
    logic [P_W-1:0]   p_reg;
    logic [D_W-1:0]   d_reg;
    logic [D_W-1:0]   rem_reg;
    logic [Q_W-1:0]   nbits_reg;
    logic [Q_W-1:0]   q_reg;
    coeff_set_t       coeff_reg;

    logic signed [C_W-1:0] m_sum;
    logic [16:0]           m_pos;
    logic [FSQ_W-1:0]      fsq;
    logic [D_W-1:0]        d_c;
    logic [N_W-1:0]        n_c;
    logic [P_W-1:0]        num_src;
    logic [D_W:0]          trial;
    logic                  trial_ge;

    assign m_sum = $signed({3'b000, cutoff_level, 1'b0}) + C_W'(cutoff_offset);
    assign m_pos = m_sum[C_W-1] ? 17'd0 : m_sum[16:0];
    assign fsq   = {sample_rate_hz, 26'd0};
    assign d_c   = D_W'(fsq) + D_W'(p_reg);
    assign num_src = (job_reg == JOB_HA) ? P_W'(fsq) : p_reg;
    assign n_c   = (N_W'(num_src) << 17) + N_W'(d_c >> 1);
    assign trial = {rem_reg, nbits_reg[Q_W-1]};
    assign trial_ge = trial >= {1'b0, d_reg};

    always_comb begin
        state_next = state_reg;
        job_next   = job_reg;
        iter_next  = iter_reg;
        unique case (state_reg)
            CS_IDLE:  if (start) state_next = CS_PREP;
            CS_PREP: begin
                job_next   = JOB_LA;
                state_next = CS_MUL;
            end
            CS_MUL:   state_next = CS_LOAD;
            CS_LOAD: begin
                iter_next  = '0;
                state_next = CS_DIV;
            end
            CS_DIV: begin
                iter_next = iter_reg + 5'd1;
                if (iter_reg == 5'(Q_W - 1)) state_next = CS_STORE;
            end
            CS_STORE: begin
                if (job_reg == JOB_HA) begin
                    state_next = CS_IDLE;
                end else begin
                    job_next   = job_reg + 2'd1;
                    state_next = CS_MUL;
                end
            end
            default: state_next = CS_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CS_IDLE;
            job_reg   <= JOB_LA;
            iter_reg  <= '0;
            coeff_reg <= '0;
        end else begin
            state_reg <= state_next;
            job_reg   <= job_next;
            iter_reg  <= iter_next;
            if (state_reg == CS_STORE) begin
                unique case (job_reg)
                    JOB_LA:  coeff_reg.low_a  <= q_reg;
                    JOB_LB:  coeff_reg.low_b  <= q_reg;
                    default: coeff_reg.high_a <= q_reg;
                endcase
            end
        end
    end

    // Datapath: the highpass job recomputes the lowpass-A product K*ca for its divisor.
    always_ff @(posedge aclk) begin
        if (state_reg == CS_PREP) begin
            ca_reg <= {m_pos, 2'b00} + C_W'(OFFS_Q18);
            cb_reg <= ({m_pos, 2'b00} + C_W'(OFFS_Q18)) >> 1;
        end
        if (state_reg == CS_MUL) begin
            p_reg <= P_W'(K_Q8) * P_W'((job_reg == JOB_LB) ? cb_reg : ca_reg);
        end
        if (state_reg == CS_LOAD) begin
            d_reg     <= d_c;
            rem_reg   <= D_W'(n_c[N_W-1:Q_W]);
            nbits_reg <= n_c[Q_W-1:0];
            q_reg     <= '0;
        end
        if (state_reg == CS_DIV) begin
            rem_reg   <= trial_ge ? D_W'(trial - {1'b0, d_reg}) : trial[D_W-1:0];
            nbits_reg <= {nbits_reg[Q_W-2:0], 1'b0};
            q_reg     <= {q_reg[Q_W-2:0], trial_ge};
        end
    end

    assign done  = (state_reg == CS_STORE) && (job_reg == JOB_HA);
    assign coeff = coeff_reg;

endmodule

`default_nettype wire

>>> rtl/resonant_filter_saturated_feedback_unit.sv
// Top level of the resonant filter with saturated feedback.
// Depends on rsf_pkg and rsf_coeff_unit; filter state lives in a local memory.
//
//  Channel  | Ports                                      | Direction
//  ---------+--------------------------------------------+----------
//  input    | s_valid, s_ready, s_in_sample              | in
//  result   | m_valid, m_ready, m_out_sample             | out
//  config   | cfg_valid, cfg_ready, cfg_index, cfg_data  | in
//
// The path from acceptance to the result register is set by the walk of the
// sequencer over the seven-entry state memory and the shared multiplier.
// Every UPDATE_INTERVAL-th sample first waits on the coefficient unit, which
// computes one product and an 18-step division for each of three coefficients.
// Reset is synchronous and active low; the state memory reads as zero after
// reset through per-entry valid bits, so no clearing pass is needed.
// A stalled result holds the sequencer in its last step; a new transaction
// is taken while a finished result still waits on the result channel.
`timescale 1ns / 1ps
`default_nettype none

module resonant_filter_saturated_feedback_unit
    import rsf_pkg::*;
#(
    parameter int UPDATE_INTERVAL = UPDATE_INTERVAL_DEF
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic signed [SAMPLE_W-1:0] s_in_sample,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic signed [SAMPLE_W-1:0]      m_out_sample,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [CFG_DATA_W-1:0]      cfg_data
);

    localparam int CNT_W = $clog2(UPDATE_INTERVAL + 1);
    localparam int OA_W  = 34;     // multiplier operand A
    localparam int OB_W  = 20;     // multiplier operand B
    localparam int PW    = OA_W + OB_W;
    localparam int X_W   = 28;     // input sample in Q1.27
    localparam int SA_W  = 29;     // clipped sum
    localparam int HIN_W = 30;     // highpass input

    localparam logic [MEM_AW-1:0] ADDR_A0 = 3'd0;
    localparam logic [MEM_AW-1:0] ADDR_A1 = 3'd1;
    localparam logic [MEM_AW-1:0] ADDR_B0 = 3'd2;
    localparam logic [MEM_AW-1:0] ADDR_B1 = 3'd3;
    localparam logic [MEM_AW-1:0] ADDR_HO = 3'd4;
    localparam logic [MEM_AW-1:0] ADDR_HI = 3'd5;
    localparam logic [MEM_AW-1:0] ADDR_FB = 3'd6;

    localparam logic signed [PW-1:0] ONE_Q27 = PW'(64'sd134217728);

    // Sequencer: one state per memory access or multiplier step.
    typedef enum logic [17:0] {
        ST_IDLE = 18'h00001,
        ST_COEF = 18'h00002,
        ST_FB   = 18'h00004,
        ST_A0   = 18'h00008,
        ST_A0W  = 18'h00010,
        ST_A1   = 18'h00020,
        ST_A1W  = 18'h00040,
        ST_B0   = 18'h00080,
        ST_B0W  = 18'h00100,
        ST_B1   = 18'h00200,
        ST_B1W  = 18'h00400,
        ST_SA   = 18'h00800,
        ST_HP   = 18'h01000,
        ST_HPW  = 18'h02000,
        ST_FBM  = 18'h04000,
        ST_FBW  = 18'h08000,
        ST_OM   = 18'h10000,
        ST_OW   = 18'h20000
    } state_t;

    function automatic logic signed [PW-1:0] rnd_shift(input logic signed [PW-1:0] v,
                                                       input logic [4:0] s);
        logic signed [PW-1:0] half;
        half = PW'(1) << (s - 5'd1);
        // Round to nearest, ties away from zero.
        if (v[PW-1]) rnd_shift = (v + half - PW'(1)) >>> s;
        else         rnd_shift = (v + half) >>> s;
    endfunction

    function automatic logic signed [STATE_W-1:0] sat32(input logic signed [PW-1:0] v);
        if (v > PW'(64'sh7fff_ffff))       sat32 = 32'sh7fff_ffff;
        else if (v < -PW'(64'sh8000_0000)) sat32 = 32'sh8000_0000;
        else                               sat32 = v[STATE_W-1:0];
    endfunction

    function automatic logic signed [PW-1:0] clip1(input logic signed [PW-1:0] v);
        if (v > ONE_Q27)       clip1 = ONE_Q27;
        else if (v < -ONE_Q27) clip1 = -ONE_Q27;
        else                   clip1 = v;
    endfunction

    // Configuration registers.
    logic [CUTOFF_W-1:0]       cutoff_level_reg;
    logic [RES_W-1:0]          resonance_gain_reg;
    logic signed [OFFS_W-1:0]  cutoff_offset_reg;
    logic [FS_W-1:0]           sample_rate_hz_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cutoff_level_reg   <= 15'd16384;
            resonance_gain_reg <= '0;
            cutoff_offset_reg  <= '0;
            sample_rate_hz_reg <= 18'd44100;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_CUTOFF_LEVEL:   cutoff_level_reg   <= cfg_data[CUTOFF_W-1:0];
                CFG_RESONANCE_GAIN: resonance_gain_reg <= cfg_data[RES_W-1:0];
                CFG_CUTOFF_OFFSET:  cutoff_offset_reg  <= cfg_data[OFFS_W-1:0];
                CFG_SAMPLE_RATE_HZ: sample_rate_hz_reg <= cfg_data[FS_W-1:0];
                default: ;
            endcase
        end
    end

    // Coefficient unit.
    logic       coef_start;
    logic       coef_done;
    coeff_set_t coeff;

    rsf_coeff_unit u_coeff (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .start          (coef_start),
        .cutoff_level   (cutoff_level_reg),
        .cutoff_offset  (cutoff_offset_reg),
        .sample_rate_hz (sample_rate_hz_reg),
        .done           (coef_done),
        .coeff          (coeff)
    );

    // Filter state memory with a registered read. Valid bits make a
    // never-written entry read as zero.
    logic signed [STATE_W-1:0] mem [MEM_DEPTH];
    logic [MEM_DEPTH-1:0]      mem_vld_reg;
    logic                      mem_we, mem_re;
    logic [MEM_AW-1:0]         mem_waddr, mem_raddr;
    logic signed [STATE_W-1:0] mem_wdata;
    logic signed [STATE_W-1:0] mem_q_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn)    mem_vld_reg <= '0;
        else if (mem_we) mem_vld_reg[mem_waddr] <= 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (mem_re) mem_q_reg <= mem_vld_reg[mem_raddr] ? mem[mem_raddr] : '0;
    end

    // Control registers.
    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                out_valid_reg, out_valid_next;
    logic [CNT_W-1:0]    cnt_inc;
    logic                s_fire;
    logic                out_load;

    // Datapath registers.
    logic signed [X_W-1:0]      x_reg;
    logic signed [STATE_W-1:0]  fb_reg, a0_reg, a1_reg, b0_reg, b1_reg, h_reg, m_reg;
    logic signed [SA_W-1:0]     sa_reg;
    logic signed [HIN_W-1:0]    hin_reg;
    logic signed [PW-1:0]       prod_reg;
    logic signed [SAMPLE_W-1:0] out_reg;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign cnt_inc  = cnt_reg + CNT_W'(1);
    assign out_load = (state_reg == ST_OW) && (!out_valid_reg || m_ready);

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        coef_start = 1'b0;
        mem_re     = 1'b0;
        mem_raddr  = ADDR_FB;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    if (cnt_inc >= CNT_W'(UPDATE_INTERVAL)) begin
                        cnt_next   = '0;
                        coef_start = 1'b1;
                        state_next = ST_COEF;
                    end else begin
                        cnt_next   = cnt_inc;
                        mem_re     = 1'b1;
                        state_next = ST_FB;
                    end
                end
            end
            ST_COEF: begin
                if (coef_done) begin
                    mem_re     = 1'b1;
                    state_next = ST_FB;
                end
            end
            ST_FB:  begin mem_re = 1'b1; mem_raddr = ADDR_A0; state_next = ST_A0; end
            ST_A0:  state_next = ST_A0W;
            ST_A0W: begin mem_re = 1'b1; mem_raddr = ADDR_A1; state_next = ST_A1; end
            ST_A1:  state_next = ST_A1W;
            ST_A1W: begin mem_re = 1'b1; mem_raddr = ADDR_B0; state_next = ST_B0; end
            ST_B0:  state_next = ST_B0W;
            ST_B0W: begin mem_re = 1'b1; mem_raddr = ADDR_B1; state_next = ST_B1; end
            ST_B1:  state_next = ST_B1W;
            ST_B1W: begin mem_re = 1'b1; mem_raddr = ADDR_HO; state_next = ST_SA; end
            ST_SA:  begin mem_re = 1'b1; mem_raddr = ADDR_HI; state_next = ST_HP; end
            ST_HP:  state_next = ST_HPW;
            ST_HPW: state_next = ST_FBM;
            ST_FBM: state_next = ST_FBW;
            ST_FBW: state_next = ST_OM;
            ST_OM:  state_next = ST_OW;
            ST_OW:  if (out_load) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (out_load)     out_valid_next = 1'b1;
        else if (m_ready) out_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Shared multiplier operand selection.
    logic signed [PW-1:0]   opa_wide;
    logic signed [OB_W-1:0] op_b;
    logic                   mul_en;
    logic signed [PW-1:0]   lp_y_wide;
    logic signed [STATE_W-1:0] lp_y;
    logic signed [PW-1:0]   sa_c, hin_c;
    logic signed [PW-1:0]   r_out;

    always_comb begin
        opa_wide = '0;
        op_b     = '0;
        mul_en   = 1'b1;
        unique case (state_reg)
            ST_A0: begin
                opa_wide = PW'(fb_reg) + PW'(x_reg) - PW'(mem_q_reg);
                op_b     = OB_W'({2'b00, coeff.low_a});
            end
            ST_A1: begin
                opa_wide = PW'(a0_reg) + PW'(fb_reg) - PW'(mem_q_reg);
                op_b     = OB_W'({2'b00, coeff.low_a});
            end
            ST_B0: begin
                opa_wide = PW'(fb_reg) + PW'(x_reg) - PW'(mem_q_reg);
                op_b     = OB_W'({2'b00, coeff.low_b});
            end
            ST_B1: begin
                opa_wide = PW'(b0_reg) - PW'(mem_q_reg);
                op_b     = OB_W'({2'b00, coeff.low_b});
            end
            ST_HP: begin
                opa_wide = PW'(hin_reg) + PW'(m_reg) - PW'(mem_q_reg);
                op_b     = OB_W'({2'b00, coeff.high_a});
            end
            ST_FBM: begin
                opa_wide = clip1(PW'(h_reg));
                op_b     = OB_W'({4'b0000, resonance_gain_reg});
            end
            ST_OM: begin
                opa_wide = PW'(h_reg) + PW'(sa_reg) + PW'(a1_reg);
                op_b     = OB_W'({4'b0000, GAIN_Q16});
            end
            default: mul_en = 1'b0;
        endcase
    end

    assign lp_y_wide = PW'(m_reg) + rnd_shift(prod_reg, 5'd17);
    assign lp_y      = sat32(lp_y_wide);
    assign sa_c      = clip1(PW'(a1_reg) + PW'(b1_reg));
    assign hin_c     = PW'(x_reg) + sa_c;
    assign r_out     = rnd_shift(prod_reg, 5'd28);

    // Memory write port.
    always_comb begin
        mem_we    = 1'b1;
        mem_waddr = ADDR_FB;
        mem_wdata = lp_y;
        unique case (state_reg)
            ST_A0W: mem_waddr = ADDR_A0;
            ST_A1W: mem_waddr = ADDR_A1;
            ST_B0W: mem_waddr = ADDR_B0;
            ST_B1W: mem_waddr = ADDR_B1;
            ST_HP: begin
                mem_waddr = ADDR_HI;
                mem_wdata = STATE_W'(hin_reg);
            end
            ST_HPW: begin
                mem_waddr = ADDR_HO;
                mem_wdata = sat32(rnd_shift(prod_reg, 5'd17));
            end
            ST_FBW: begin
                mem_waddr = ADDR_FB;
                mem_wdata = STATE_W'(clip1(rnd_shift(prod_reg, 5'd13)));
            end
            default: mem_we = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (s_fire) x_reg <= {s_in_sample, 12'd0};
        if (mul_en) prod_reg <= PW'($signed(opa_wide[OA_W-1:0])) * PW'(op_b);
        unique case (state_reg)
            ST_FB:  fb_reg <= mem_q_reg;
            ST_A0, ST_A1, ST_B0, ST_B1, ST_SA: m_reg <= mem_q_reg;
            ST_A0W: a0_reg <= lp_y;
            ST_A1W: a1_reg <= lp_y;
            ST_B0W: b0_reg <= lp_y;
            ST_B1W: b1_reg <= lp_y;
            ST_HPW: h_reg  <= sat32(rnd_shift(prod_reg, 5'd17));
            default: ;
        endcase
        if (state_reg == ST_SA) begin
            sa_reg  <= sa_c[SA_W-1:0];
            hin_reg <= hin_c[HIN_W-1:0];
        end
        if (out_load) begin
            if (r_out > PW'(32767))       out_reg <= 16'sh7fff;
            else if (r_out < -PW'(32768)) out_reg <= 16'sh8000;
            else                          out_reg <= r_out[SAMPLE_W-1:0];
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_out_sample = out_reg;

endmodule

`default_nettype wire

>>> rtl/rsf_checker.sv
// Port-level checker for the resonant filter top level, with its bind.
// Depends on rsf_pkg for the sample width.
`timescale 1ns / 1ps
`default_nettype none

module rsf_checker
    import rsf_pkg::*;
(
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_valid,
    input wire logic                s_ready,
    input wire logic                m_valid,
    input wire logic                m_ready,
    input wire logic [SAMPLE_W-1:0] m_out_sample
);

    // A result that is not taken stays offered.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result withdrawn before transaction");

    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_out_sample))
        else $error("stalled result changed");

    // One sample is worked at a time: no input transaction right after one.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken on consecutive cycles");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result offered after reset");

endmodule

bind resonant_filter_saturated_feedback_unit rsf_checker u_rsf_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_out_sample (m_out_sample)
);

`default_nettype wire

>>> tb/tb_top.sv
// Self-checking testbench for resonant_filter_saturated_feedback_unit.
// Depends on rsf_pkg and the filter RTL; holds its own bit-exact filter predictor.
`timescale 1ns / 1ps

module tb_top;
    import rsf_pkg::*;

    // Clock, reset and port signals.
    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [SAMPLE_W-1:0] s_in_sample = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [SAMPLE_W-1:0] m_out_sample;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    resonant_filter_saturated_feedback_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_in_sample(s_in_sample),
        .m_valid(m_valid), .m_ready(m_ready), .m_out_sample(m_out_sample),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // Predictor state: the registers, the seven state words and the three
    // coefficients at the block's widths, and the sample counter.
    logic [CUTOFF_W-1:0] p_cutoff;
    logic [RES_W-1:0] p_res;
    logic signed [OFFS_W-1:0] p_offset;
    logic [FS_W-1:0] p_fs;
    logic signed [STATE_W-1:0] p_mem [MEM_DEPTH];
    int unsigned p_count;
    logic [COEF_W-1:0] p_low_a, p_low_b, p_high_a;

    logic signed [SAMPLE_W-1:0] pending_samples [$];
    logic signed [SAMPLE_W-1:0] expected_samples [$];
    int errors = 0;
    bit idle_enable = 1'b0;
    bit s_fired = 1'b0;
    longint cycle = 0;

    // Right shift rounded to nearest with ties away from zero.
    function automatic longint rshift_round(longint v, int s);
        longint half;
        half = longint'(1) << (s - 1);
        if (v < 0) return -((-v + half) >>> s);
        return (v + half) >>> s;
    endfunction

    function automatic longint sat_state(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint clip_unit(longint v);
        longint one;
        one = longint'(1) << 27;
        if (v > one) return one;
        if (v < -one) return -one;
        return v;
    endfunction

    // Lowpass: P/D; highpass: fs*2^26/D; with P = K*c and D = fs*2^26 + P.
    function automatic logic [COEF_W-1:0] lowpass_coef(longint unsigned c18);
        longint unsigned pk, dd;
        pk = longint'(K_Q8) * c18;
        dd = (longint'(p_fs) << 26) + pk;
        return COEF_W'(((pk << 17) + dd / 2) / dd);
    endfunction

    function automatic logic [COEF_W-1:0] highpass_coef(longint unsigned c18);
        longint unsigned fsq, dd;
        fsq = longint'(p_fs) << 26;
        dd = fsq + longint'(K_Q8) * c18;
        return COEF_W'(((fsq << 17) + dd / 2) / dd);
    endfunction

    function automatic longint lowpass_stage(int idx, longint x, logic [COEF_W-1:0] a);
        longint m, y;
        m = p_mem[idx];
        y = sat_state(m + rshift_round((x - m) * longint'(a), 17));
        p_mem[idx] = STATE_W'(y);
        return y;
    endfunction

    function automatic void reset_filter_model();
        foreach (p_mem[i]) p_mem[i] = '0;
        p_count = 0;
        p_low_a = '0;
        p_low_b = '0;
        p_high_a = '0;
        p_cutoff = 15'd16384;
        p_res = '0;
        p_offset = '0;
        p_fs = 18'd44100;
    endfunction

    function automatic void write_model_register(logic [CFG_IDX_W-1:0] idx,
                                                 logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_CUTOFF_LEVEL: p_cutoff = val[CUTOFF_W-1:0];
            CFG_RESONANCE_GAIN: p_res = val[RES_W-1:0];
            CFG_CUTOFF_OFFSET: p_offset = val[OFFS_W-1:0];
            CFG_SAMPLE_RATE_HZ: p_fs = val[FS_W-1:0];
            default: ;
        endcase
    endfunction

    // Computes the filtered sample for one input and advances the state.
    function automatic logic signed [SAMPLE_W-1:0] filter_sample(
            logic signed [SAMPLE_W-1:0] smp);
        longint x, fb, a0in, a0, a1, b0, b1, sa, hin, h, sb, sc, r, mcut;
        longint unsigned ca;
        x = longint'(smp) * 4096;
        p_count = (p_count + 1) & 16'hFFFF;
        if (p_count >= UPDATE_INTERVAL_DEF) begin
            mcut = 2 * longint'(p_cutoff) + longint'(p_offset);
            if (mcut < 0) mcut = 0;
            ca = 4 * mcut + longint'(OFFS_Q18);
            p_low_a = lowpass_coef(ca);
            p_low_b = lowpass_coef(ca >> 1);
            p_high_a = highpass_coef(ca);
            p_count = 0;
        end
        fb = p_mem[6];
        a0in = fb + x;
        a0 = lowpass_stage(0, a0in, p_low_a);
        a1 = lowpass_stage(1, a0 + fb, p_low_a);
        b0 = lowpass_stage(2, a0in, p_low_b);
        b1 = lowpass_stage(3, b0, p_low_b);
        sa = clip_unit(a1 + b1);
        hin = x + sa;
        h = sat_state(rshift_round((hin + p_mem[4] - p_mem[5]) * longint'(p_high_a), 17));
        p_mem[4] = STATE_W'(h);
        p_mem[5] = STATE_W'(sat_state(hin));
        sb = clip_unit(h);
        sc = clip_unit(rshift_round(sb * longint'(p_res), 13));
        p_mem[6] = STATE_W'(sc);
        r = rshift_round((h + sa + a1) * longint'(GAIN_Q16), 28);
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return SAMPLE_W'(r);
    endfunction

    // Idling is chosen with a chance of 7 in 100 at each call, and only while idle_enable is set.
    function automatic bit take_break();
        return idle_enable && ($urandom_range(99) < 7);
    endfunction

    // Sample driver: inputs change on the falling edge. A transaction is
    // accepted at the rising edge where valid and ready are both high, and
    // the prediction is made at that moment.
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            expected_samples.push_back(filter_sample(s_in_sample));
            void'(pending_samples.pop_front());
            s_fired = 1'b1;
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !s_fired) begin
            // Hold the pending transaction unchanged.
        end else if (pending_samples.size() > 0 && !take_break()) begin
            // The head was already popped if the last one was just accepted.
            s_valid <= 1'b1;
            s_in_sample <= pending_samples[0];
        end else begin
            s_valid <= 1'b0;
        end
        s_fired = 1'b0;
    end

    // Result monitor: compares each result against the oldest prediction.
    always @(posedge aclk) begin
        cycle <= cycle + 1;
        if (aresetn && m_valid && m_ready) begin
            if (expected_samples.size() == 0) begin
                $error("out_sample: unexpected result, actual %0d", m_out_sample);
                errors++;
            end else begin
                if (m_out_sample !== expected_samples[0]) begin
                    $error("out_sample: expected %0d, actual %0d",
                           expected_samples[0], m_out_sample);
                    errors++;
                end
                void'(expected_samples.pop_front());
            end
        end
    end

    always @(negedge aclk) begin
        m_ready <= aresetn && !take_break();
    end

    // Watchdog against a hung block.
    always @(posedge aclk) begin
        if (cycle > 2000000) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        write_model_register(idx, val);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Waits until every queued sample has gone through and its result has arrived.
    task automatic drain();
        while (pending_samples.size() > 0 || expected_samples.size() > 0 || s_valid)
            @(posedge aclk);
        repeat (120) @(posedge aclk);
    endtask

    // Extremes, full-range random and small (-2000..2000) samples, mixed.
    task automatic queue_samples(int n);
        int kind;
        for (int i = 0; i < n; i++) begin
            kind = $urandom_range(9);
            if (kind == 0)
                pending_samples.push_back($urandom_range(1) ? 16'sh7FFF : 16'sh8000);
            else if (kind < 4)
                pending_samples.push_back(SAMPLE_W'($urandom));
            else
                pending_samples.push_back(SAMPLE_W'($signed($urandom_range(4000)) - 2000));
        end
    endtask

    initial begin
        logic [CFG_DATA_W-1:0] setting;
        reset_filter_model();
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: before the first recomputation the output is zero; then
        // extremes of the sample range carry through the first update.
        pending_samples.push_back(16'sh7FFF);
        pending_samples.push_back(16'sh8000);
        pending_samples.push_back(16'sh0000);
        pending_samples.push_back(16'sh0001);
        pending_samples.push_back(16'shFFFF);
        for (int i = 0; i < 15; i++)
            pending_samples.push_back(i[0] ? 16'sh7FFF : 16'sh8000);
        drain();

        // Directed settings: extremes of every register, negative modulated
        // cutoff, out-of-range and zero sample rates, an index beyond the list.
        write_register(CFG_CUTOFF_LEVEL, 32'h7FFF);
        write_register(CFG_RESONANCE_GAIN, 32'hFFFF);
        write_register(CFG_CUTOFF_OFFSET, 32'h7FFF);
        write_register(CFG_SAMPLE_RATE_HZ, 32'd8000);
        write_register(8'd4, 32'hFFFF_FFFF);
        queue_samples(40);
        drain();
        write_register(CFG_CUTOFF_LEVEL, 32'h0);
        write_register(CFG_CUTOFF_OFFSET, 32'h8000);
        write_register(CFG_SAMPLE_RATE_HZ, 32'd192000);
        write_register(CFG_RESONANCE_GAIN, 32'h0);
        queue_samples(40);
        drain();
        write_register(CFG_SAMPLE_RATE_HZ, 32'h0);
        write_register(CFG_CUTOFF_LEVEL, 32'h4000);
        queue_samples(20);
        drain();
        write_register(CFG_SAMPLE_RATE_HZ, 32'h3FFFF);
        write_register(CFG_CUTOFF_OFFSET, 32'hFFFF_FFFF);
        queue_samples(20);
        drain();

        // Random phases with random settings; the first phase runs without
        // idling so the block is exercised back to back.
        for (int phase = 0; phase < 12; phase++) begin
            idle_enable = (phase != 0);
            setting = $urandom;
            write_register(CFG_CUTOFF_LEVEL, setting);
            write_register(CFG_RESONANCE_GAIN, $urandom_range(3) == 0 ? $urandom : $urandom_range(20000));
            write_register(CFG_CUTOFF_OFFSET, $urandom);
            write_register(CFG_SAMPLE_RATE_HZ, $urandom_range(8000, 192000));
            queue_samples(140);
            drain();
        end

        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

>>> resonant_filter_saturated_feedback_unit.f
rtl/rsf_pkg.sv
rtl/rsf_coeff_unit.sv
rtl/resonant_filter_saturated_feedback_unit.sv
rtl/rsf_checker.sv
tb/tb_top.sv
